// ===== rtl/gsp_pkg.sv =====
// Package of the graph next-hop core: widths, command and status codes,
// and the saturating cost adder and scan helper.
// No dependencies.
`default_nettype none

package gsp_pkg;

  localparam int NUM_NODES   = 64;
  localparam int NODE_W      = $clog2(NUM_NODES);
  localparam int NODE_CNT_W  = NODE_W + 1;
  localparam int NUM_EDGES   = 8;
  localparam int SLOT_W      = $clog2(NUM_EDGES);
  localparam int CNT_W       = SLOT_W + 1;
  localparam int EDGE_DEPTH  = NUM_NODES * NUM_EDGES;
  localparam int ECOST_W     = 16;
  localparam int COST_W      = 24;
  localparam int EDGE_DATA_W = NODE_W + ECOST_W;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 2;
  localparam int ROUND_W     = NODE_CNT_W;
  localparam logic [ROUND_W-1:0] ROUND_LIMIT = ROUND_W'(NUM_NODES + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD_NODE   = 3'd0,
    CMD_REMOVE     = 3'd1,
    CMD_CLEAR      = 3'd2,
    CMD_ADD_EDGE   = 3'd3,
    CMD_NAVIGATE   = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_ABSENT   = 2'd2,
    ST_NO_ROUTE = 2'd3
  } status_e;

  // Adds an edge cost to a path cost, clamping at the all-ones value.
  function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
                                                input logic [ECOST_W-1:0] b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {(COST_W - ECOST_W + 1)'(0), b};
    return s[COST_W] ? {COST_W{1'b1}} : s[COST_W-1:0];
  endfunction

  // Lowest set bit of a node set.
  function automatic logic [NODE_W-1:0] first_set(input logic [NUM_NODES-1:0] m);
    logic [NODE_W-1:0] idx;
    idx = '0;
    for (int j = NUM_NODES - 1; j >= 0; j--) begin
      if (m[j]) idx = NODE_W'(j);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/gsp_in_if.sv =====
// Command channel of the graph next-hop core: valid, ready and one command.
// Depends on gsp_pkg.
`default_nettype none

interface gsp_in_if;
  import gsp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CMD_W-1:0]      command;
  logic [NODE_W-1:0]     node_index;
  logic [NODE_W-1:0]     neighbor_index;
  logic [ECOST_W-1:0]    edge_cost;
  logic                  destination_only;
  logic [NODE_W-1:0]     start_node;
  logic [NODE_W-1:0]     goal_node;

  modport source(output valid, command, node_index, neighbor_index, edge_cost,
                 destination_only, start_node, goal_node, input ready);
  modport sink(input valid, command, node_index, neighbor_index, edge_cost,
               destination_only, start_node, goal_node, output ready);
endinterface

`default_nettype wire

// ===== rtl/gsp_out_if.sv =====
// Result channel of the graph next-hop core: valid, ready and one result.
// Depends on gsp_pkg.
`default_nettype none

interface gsp_out_if;
  import gsp_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [NODE_W-1:0]   node_out;
  logic [COST_W-1:0]   path_cost;

  modport source(output valid, status, node_out, path_cost, input ready);
  modport sink(input valid, status, node_out, path_cost, output ready);
endinterface

`default_nettype wire

// ===== rtl/graph_shortest_path_next_hop_core.sv =====
// Graph next-hop core: node and edge tables with a level-by-level
// shortest-path search from the goal node.
// Depends on gsp_pkg, gsp_in_if, gsp_out_if and gsp_ram.
//
// Usage: each transaction on in_i carries one command; every command gives
// exactly one transaction on out_o with a status, a node index and a path
// cost. Commands are taken one at a time; in_i.ready is high while the core
// is idle, also while a previous result still waits in the output register.
// Steps: add node and clear edges pass the execute state and then the output
// register; add edge reads the edge count in between. Remove node sweeps
// every present node's edge list: it reads the node's edge count, then each
// stored edge, writing back the ones kept. Navigate runs up to 66 levels; each
// level finds each frontier node, fetches its edge count and cost, and per
// edge fetches the edge, then reads the cost of a target it may enter,
// compares and writes back. The edge table and the cost memory each have a
// single read port.
// Reset clears the node table, the route valid bits and the output; edge
// and cost memories need no clearing. When out_o.ready is low the finished
// result waits in its register and the next result is held back until it is
// taken.
`default_nettype none

module graph_shortest_path_next_hop_core
  import gsp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gsp_in_if.sink    in_i,
  gsp_out_if.source out_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_ADDE, S_RM_CNT, S_RM_CNTD, S_RM_DATA,
    S_NV_FIND, S_NV_NODE, S_NV_EDGE, S_NV_CMP, S_NV_RES, S_RESP
  } state_e;

  state_e                state_q, state_d;
  logic [CMD_W-1:0]      cmd_q, cmd_d;
  logic [NODE_W-1:0]     node_q, node_d, nbr_q, nbr_d, start_q, start_d, goal_q, goal_d;
  logic [ECOST_W-1:0]    ecost_q, ecost_d;
  logic                  dest_q, dest_d;
  logic [NUM_NODES-1:0]  present_q, present_d, donly_q, donly_d;
  logic [NUM_NODES-1:0]  cvalid_q, cvalid_d, hvalid_q, hvalid_d, cur_q, cur_d, nxt_q, nxt_d;
  logic [NODE_CNT_W-1:0] free_q, free_d, ptr_q, ptr_d;
  logic [NODE_W-1:0]     idx_q, idx_d, tgt_q, tgt_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d, w_q, w_d;
  logic [SLOT_W-1:0]     k_q, k_d;
  logic [COST_W-1:0]     costi_q, costi_d;
  logic [ECOST_W-1:0]    ecst_q, ecst_d;
  logic                  any_q, any_d;
  logic [ROUND_W-1:0]    rounds_q, rounds_d;
  logic [STATUS_W-1:0]   rst_q, rst_d;
  logic [NODE_W-1:0]     rnode_q, rnode_d;
  logic [COST_W-1:0]     rcost_q, rcost_d;
  logic                  ovalid_q, ovalid_d;
  logic [STATUS_W-1:0]   ostat_q, ostat_d;
  logic [NODE_W-1:0]     onode_q, onode_d;
  logic [COST_W-1:0]     ocost_q, ocost_d;

  // Memory ports.
  logic                         cnt_we;
  logic [NODE_W-1:0]            cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]             cnt_wdata, cnt_rdata;
  logic                         edge_we;
  logic [NODE_W+SLOT_W-1:0]     edge_waddr, edge_raddr;
  logic [EDGE_DATA_W-1:0]       edge_wdata, edge_rdata;
  logic                         cost_we;
  logic [NODE_W-1:0]            cost_waddr, cost_raddr;
  logic [COST_W-1:0]            cost_wdata, cost_rdata;
  logic                         hop_we;
  logic [NODE_W-1:0]            hop_waddr, hop_raddr;
  logic [NODE_W-1:0]            hop_wdata, hop_rdata;

  logic [NUM_NODES-1:0]  scan_mask, scan_set;
  logic [NODE_W-1:0]     scan_idx;
  logic [NODE_W-1:0]     e_tgt;
  logic [ECOST_W-1:0]    e_cost;
  logic                  e_ok, more_edges, keep;
  logic [COST_W-1:0]     sum;
  logic [CNT_W-1:0]      k_next;
  logic [NODE_CNT_W-1:0] idx_next;

  gsp_ram #(.WIDTH(CNT_W), .DEPTH(NUM_NODES)) u_cnt_ram (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_waddr), .wdata_i(cnt_wdata),
    .raddr_i(cnt_raddr), .rdata_o(cnt_rdata)
  );
  gsp_ram #(.WIDTH(EDGE_DATA_W), .DEPTH(EDGE_DEPTH)) u_edge_ram (
    .clk_i, .we_i(edge_we), .waddr_i(edge_waddr), .wdata_i(edge_wdata),
    .raddr_i(edge_raddr), .rdata_o(edge_rdata)
  );
  gsp_ram #(.WIDTH(COST_W), .DEPTH(NUM_NODES)) u_cost_ram (
    .clk_i, .we_i(cost_we), .waddr_i(cost_waddr), .wdata_i(cost_wdata),
    .raddr_i(cost_raddr), .rdata_o(cost_rdata)
  );
  gsp_ram #(.WIDTH(NODE_W), .DEPTH(NUM_NODES)) u_hop_ram (
    .clk_i, .we_i(hop_we), .waddr_i(hop_waddr), .wdata_i(hop_wdata),
    .raddr_i(hop_raddr), .rdata_o(hop_rdata)
  );

  assign in_i.ready      = (state_q == S_IDLE);
  assign out_o.valid     = ovalid_q;
  assign out_o.status    = ostat_q;
  assign out_o.node_out  = onode_q;
  assign out_o.path_cost = ocost_q;

  always_comb begin
    for (int j = 0; j < NUM_NODES; j++) begin
      scan_mask[j] = (NODE_CNT_W'(j) >= ptr_q);
    end
    scan_set   = cur_q & scan_mask;
    scan_idx   = first_set(scan_set);
    e_tgt      = edge_rdata[EDGE_DATA_W-1:ECOST_W];
    e_cost     = edge_rdata[ECOST_W-1:0];
    // Destination-only nodes are entered only as the start or the goal.
    e_ok       = present_q[e_tgt] &&
                 !(e_tgt != start_q && e_tgt != goal_q && donly_q[e_tgt]);
    sum        = sat_add(costi_q, ecst_q);
    k_next     = {1'b0, k_q} + CNT_W'(1);
    more_edges = (k_next < cnt_q);
    idx_next   = {1'b0, idx_q} + NODE_CNT_W'(1);
    keep       = (e_tgt != node_q);
  end

  always_comb begin
    state_d = state_q;   cmd_d = cmd_q;       node_d = node_q;   nbr_d = nbr_q;
    start_d = start_q;   goal_d = goal_q;     ecost_d = ecost_q; dest_d = dest_q;
    present_d = present_q; donly_d = donly_q; cvalid_d = cvalid_q;
    hvalid_d = hvalid_q; cur_d = cur_q;       nxt_d = nxt_q;     free_d = free_q;
    ptr_d = ptr_q;       idx_d = idx_q;       tgt_d = tgt_q;     cnt_d = cnt_q;
    w_d = w_q;           k_d = k_q;           costi_d = costi_q; ecst_d = ecst_q;
    any_d = any_q;       rounds_d = rounds_q;
    rst_d = rst_q;       rnode_d = rnode_q;   rcost_d = rcost_q;
    ovalid_d = ovalid_q && !out_o.ready;
    ostat_d = ostat_q;   onode_d = onode_q;   ocost_d = ocost_q;

    cnt_we = 1'b0;  cnt_waddr = node_q; cnt_wdata = '0; cnt_raddr = node_q;
    edge_we = 1'b0; edge_waddr = {idx_q, w_q[SLOT_W-1:0]}; edge_wdata = edge_rdata;
    edge_raddr = {idx_q, k_q};
    cost_we = 1'b0; cost_waddr = tgt_q; cost_wdata = sum; cost_raddr = tgt_q;
    hop_we = 1'b0;  hop_waddr = tgt_q;  hop_wdata = idx_q; hop_raddr = start_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          cmd_d   = in_i.command;
          node_d  = in_i.node_index;
          nbr_d   = in_i.neighbor_index;
          ecost_d = in_i.edge_cost;
          dest_d  = in_i.destination_only;
          start_d = in_i.start_node;
          goal_d  = in_i.goal_node;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        rst_d   = ST_OK;
        rnode_d = '0;
        rcost_d = '0;
        state_d = S_RESP;
        case (cmd_q)
          CMD_ADD_NODE: begin
            if (free_q[NODE_CNT_W-1]) begin
              rst_d = ST_FULL;
            end else begin
              present_d[free_q[NODE_W-1:0]] = 1'b1;
              donly_d[free_q[NODE_W-1:0]]   = dest_q;
              cnt_we    = 1'b1;
              cnt_waddr = free_q[NODE_W-1:0];
              rnode_d   = free_q[NODE_W-1:0];
              free_d    = free_q + NODE_CNT_W'(1);
            end
          end
          CMD_REMOVE: begin
            if (!present_q[node_q]) begin
              rst_d = ST_ABSENT;
            end else begin
              present_d[node_q] = 1'b0;
              cnt_we   = 1'b1;
              cvalid_d = '0;
              hvalid_d = '0;
              ptr_d    = '0;
              state_d  = S_RM_CNT;
            end
          end
          CMD_CLEAR: begin
            if (!present_q[node_q]) rst_d = ST_ABSENT;
            else cnt_we = 1'b1;
          end
          CMD_ADD_EDGE: begin
            if (!present_q[node_q] || !present_q[nbr_q]) begin
              rst_d = ST_ABSENT;
            end else begin
              state_d = S_ADDE;
            end
          end
          CMD_NAVIGATE: begin
            if (!present_q[start_q] || !present_q[goal_q]) begin
              rst_d = ST_ABSENT;
            end else begin
              cvalid_d = '0;
              cvalid_d[goal_q] = 1'b1;
              hvalid_d = '0;
              cur_d    = '0;
              cur_d[goal_q] = 1'b1;
              nxt_d    = '0;
              cost_we    = 1'b1;
              cost_waddr = goal_q;
              cost_wdata = '0;
              rounds_d = '0;
              ptr_d    = '0;
              any_d    = 1'b0;
              state_d  = S_NV_FIND;
            end
          end
          default: ;
        endcase
      end

      S_ADDE: begin
        if (cnt_rdata >= CNT_W'(NUM_EDGES)) begin
          rst_d = ST_FULL;
        end else begin
          edge_we    = 1'b1;
          edge_waddr = {node_q, cnt_rdata[SLOT_W-1:0]};
          edge_wdata = {nbr_q, ecost_q};
          cnt_we     = 1'b1;
          cnt_wdata  = cnt_rdata + CNT_W'(1);
        end
        state_d = S_RESP;
      end

      // Remove: compact every present node's edge list in place.
      S_RM_CNT: begin
        idx_d = ptr_q[NODE_W-1:0];
        if (ptr_q[NODE_CNT_W-1]) begin
          state_d = S_RESP;
        end else if (!present_q[ptr_q[NODE_W-1:0]]) begin
          ptr_d = ptr_q + NODE_CNT_W'(1);
        end else begin
          cnt_raddr = ptr_q[NODE_W-1:0];
          state_d   = S_RM_CNTD;
        end
      end

      S_RM_CNTD: begin
        cnt_d = cnt_rdata;
        k_d   = '0;
        w_d   = '0;
        if (cnt_rdata == '0) begin
          ptr_d   = ptr_q + NODE_CNT_W'(1);
          state_d = S_RM_CNT;
        end else begin
          edge_raddr = {idx_q, SLOT_W'(0)};
          state_d    = S_RM_DATA;
        end
      end

      S_RM_DATA: begin
        // The write slot never passes the read slot, so no entry is lost.
        if (keep) begin
          edge_we = 1'b1;
          w_d     = w_q + CNT_W'(1);
        end
        if (more_edges) begin
          k_d        = k_next[SLOT_W-1:0];
          edge_raddr = {idx_q, k_next[SLOT_W-1:0]};
        end else begin
          cnt_we    = 1'b1;
          cnt_waddr = idx_q;
          cnt_wdata = keep ? w_q + CNT_W'(1) : w_q;
          ptr_d     = ptr_q + NODE_CNT_W'(1);
          state_d   = S_RM_CNT;
        end
      end

      S_NV_FIND: begin
        if (|scan_set) begin
          idx_d      = scan_idx;
          cnt_raddr  = scan_idx;
          cost_raddr = scan_idx;
          state_d    = S_NV_NODE;
        end else begin
          rounds_d = rounds_q + ROUND_W'(1);
          cur_d    = nxt_q;
          nxt_d    = '0;
          ptr_d    = '0;
          any_d    = 1'b0;
          if (any_q && rounds_q < ROUND_LIMIT) begin
            state_d = S_NV_FIND;
          end else begin
            cur_d      = '0;
            cost_raddr = start_q;
            state_d    = S_NV_RES;
          end
        end
      end

      S_NV_NODE: begin
        cnt_d   = cnt_rdata;
        costi_d = cost_rdata;
        k_d     = '0;
        if (cnt_rdata == '0) begin
          ptr_d   = idx_next;
          state_d = S_NV_FIND;
        end else begin
          edge_raddr = {idx_q, SLOT_W'(0)};
          state_d    = S_NV_EDGE;
        end
      end

      S_NV_EDGE: begin
        tgt_d  = e_tgt;
        ecst_d = e_cost;
        if (e_ok) begin
          cost_raddr = e_tgt;
          state_d    = S_NV_CMP;
        end else if (more_edges) begin
          k_d        = k_next[SLOT_W-1:0];
          edge_raddr = {idx_q, k_next[SLOT_W-1:0]};
        end else begin
          ptr_d   = idx_next;
          state_d = S_NV_FIND;
        end
      end

      S_NV_CMP: begin
        if (!cvalid_q[tgt_q] || sum < cost_rdata) begin
          cost_we         = 1'b1;
          hop_we          = 1'b1;
          cvalid_d[tgt_q] = 1'b1;
          hvalid_d[tgt_q] = 1'b1;
          nxt_d[tgt_q]    = 1'b1;
          any_d           = 1'b1;
        end
        if (more_edges) begin
          k_d        = k_next[SLOT_W-1:0];
          edge_raddr = {idx_q, k_next[SLOT_W-1:0]};
          state_d    = S_NV_EDGE;
        end else begin
          ptr_d   = idx_next;
          state_d = S_NV_FIND;
        end
      end

      S_NV_RES: begin
        if (hvalid_q[start_q]) begin
          rst_d   = ST_OK;
          rnode_d = hop_rdata;
          rcost_d = cost_rdata;
        end else begin
          rst_d = ST_NO_ROUTE;
        end
        state_d = S_RESP;
      end

      S_RESP: begin
        if (!ovalid_q || out_o.ready) begin
          ovalid_d = 1'b1;
          ostat_d  = rst_q;
          onode_d  = rnode_q;
          ocost_d  = rcost_q;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;   cmd_q <= '0;    node_q <= '0;  nbr_q <= '0;
      start_q <= '0;       goal_q <= '0;   ecost_q <= '0; dest_q <= 1'b0;
      present_q <= '0;     donly_q <= '0;  cvalid_q <= '0; hvalid_q <= '0;
      cur_q <= '0;         nxt_q <= '0;    free_q <= '0;  ptr_q <= '0;
      idx_q <= '0;         tgt_q <= '0;    cnt_q <= '0;   w_q <= '0;
      k_q <= '0;           costi_q <= '0;  ecst_q <= '0;  any_q <= 1'b0;
      rounds_q <= '0;      rst_q <= '0;    rnode_q <= '0; rcost_q <= '0;
      ovalid_q <= 1'b0;    ostat_q <= '0;  onode_q <= '0; ocost_q <= '0;
    end else begin
      state_q <= state_d;  cmd_q <= cmd_d;   node_q <= node_d; nbr_q <= nbr_d;
      start_q <= start_d;  goal_q <= goal_d; ecost_q <= ecost_d; dest_q <= dest_d;
      present_q <= present_d; donly_q <= donly_d; cvalid_q <= cvalid_d;
      hvalid_q <= hvalid_d; cur_q <= cur_d;  nxt_q <= nxt_d;   free_q <= free_d;
      ptr_q <= ptr_d;      idx_q <= idx_d;   tgt_q <= tgt_d;   cnt_q <= cnt_d;
      w_q <= w_d;          k_q <= k_d;       costi_q <= costi_d; ecst_q <= ecst_d;
      any_q <= any_d;      rounds_q <= rounds_d;
      rst_q <= rst_d;      rnode_q <= rnode_d; rcost_q <= rcost_d;
      ovalid_q <= ovalid_d; ostat_q <= ostat_d; onode_q <= onode_d; ocost_q <= ocost_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gsp_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module gsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/gsp_chk.sv =====
// Port-level checks of the graph next-hop core and their bind.
// Depends on gsp_pkg and graph_shortest_path_next_hop_core.
`default_nettype none

module gsp_chk
  import gsp_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                in_valid_i,
  input wire logic                in_ready_i,
  input wire logic                out_valid_i,
  input wire logic                out_ready_i,
  input wire logic [STATUS_W-1:0] status_i,
  input wire logic [NODE_W-1:0]   node_out_i,
  input wire logic [COST_W-1:0]   path_cost_i
);

  // A result that is not taken stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i) &&
    $stable(node_out_i) && $stable(path_cost_i))
    else $error("result changed while stalled");

  // Only one command is in work at a time.
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second command accepted while busy");

  a_err_cost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_OK |-> path_cost_i == '0)
    else $error("failed command reports a path cost");

  a_err_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != ST_OK |-> node_out_i == '0)
    else $error("failed command reports a node");

endmodule

bind graph_shortest_path_next_hop_core gsp_chk u_gsp_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .status_i    (out_o.status),
  .node_out_i  (out_o.node_out),
  .path_cost_i (out_o.path_cost)
);

`default_nettype wire

// ===== bench/tb_route_checker.sv =====
// Route result checker of the graph next-hop core bench: holds a copy of the
// graph, predicts each command's result and compares it. Depends on gsp_pkg.
`timescale 1ns / 1ps

class route_checker;
  typedef struct packed {
    logic [gsp_pkg::STATUS_W-1:0] status;
    logic [gsp_pkg::NODE_W-1:0]   node_out;
    logic [gsp_pkg::COST_W-1:0]   path_cost;
  } route_result_t;

  bit                          present [64];
  bit                          dest_only [64];
  int unsigned                 free_index;
  logic [5:0]                  edge_target [64][8];
  logic [15:0]                 edge_weight [64][8];
  int unsigned                 edge_num [64];
  route_result_t               pending_results[$];
  int unsigned                 errors;
  int unsigned                 checked;
  int unsigned                 routes_found;

  function void clear_graph();
    free_index = 0;
    for (int i = 0; i < 64; i++) begin
      present[i] = 0;
      dest_only[i] = 0;
      edge_num[i] = 0;
    end
  endfunction

  function bit is_live(int unsigned n);
    return n < 64 && present[n];
  endfunction

  // Level-by-level relaxation from the goal, frontier scanned in index order.
  function route_result_t find_route(int unsigned start, int unsigned goal);
    route_result_t res;
    bit            visited [64];
    bit            has_hop [64];
    int unsigned   cost [64];
    int unsigned   hop [64];
    bit            cur_set [64];
    bit            nxt_set [64];
    bit            any;
    int unsigned   rounds;
    int unsigned   t;
    int unsigned   sum;
    res = '0;
    for (int i = 0; i < 64; i++) begin
      visited[i] = 0;
      has_hop[i] = 0;
      cost[i] = 0;
      hop[i] = 0;
      cur_set[i] = 0;
    end
    visited[goal] = 1;
    cur_set[goal] = 1;
    any = 1;
    rounds = 0;
    while (any && rounds <= 65) begin
      for (int i = 0; i < 64; i++) nxt_set[i] = 0;
      any = 0;
      for (int i = 0; i < 64; i++) begin
        if (cur_set[i]) begin
          for (int k = 0; k < edge_num[i]; k++) begin
            t = edge_target[i][k];
            if (is_live(t) && !(t != start && t != goal && dest_only[t])) begin
              sum = cost[i] + edge_weight[i][k];
              if (sum > 24'hFFFFFF) sum = 24'hFFFFFF;
              if (!visited[t] || sum < cost[t]) begin
                cost[t] = sum;
                visited[t] = 1;
                hop[t] = i;
                has_hop[t] = 1;
                nxt_set[t] = 1;
                any = 1;
              end
            end
          end
        end
      end
      cur_set = nxt_set;
      rounds++;
    end
    if (has_hop[start]) begin
      res.status = gsp_pkg::ST_OK;
      res.node_out = 6'(hop[start]);
      res.path_cost = 24'(cost[start]);
    end else begin
      res.status = gsp_pkg::ST_NO_ROUTE;
    end
    return res;
  endfunction

  function void note_command(logic [2:0] cmd, logic [5:0] node, logic [5:0] nbr,
                             logic [15:0] ecost, logic dest, logic [5:0] start,
                             logic [5:0] goal);
    route_result_t res;
    int unsigned   w;
    res = '0;
    case (cmd)
      gsp_pkg::CMD_ADD_NODE: begin
        if (free_index >= 64) begin
          res.status = gsp_pkg::ST_FULL;
        end else begin
          present[free_index] = 1;
          dest_only[free_index] = dest;
          edge_num[free_index] = 0;
          res.node_out = 6'(free_index);
          free_index++;
        end
      end
      gsp_pkg::CMD_REMOVE: begin
        if (!is_live(node)) begin
          res.status = gsp_pkg::ST_ABSENT;
        end else begin
          present[node] = 0;
          edge_num[node] = 0;
          for (int i = 0; i < 64; i++) begin
            w = 0;
            for (int k = 0; k < edge_num[i]; k++) begin
              if (edge_target[i][k] != node) begin
                edge_target[i][w] = edge_target[i][k];
                edge_weight[i][w] = edge_weight[i][k];
                w++;
              end
            end
            edge_num[i] = w;
          end
        end
      end
      gsp_pkg::CMD_CLEAR: begin
        if (!is_live(node)) res.status = gsp_pkg::ST_ABSENT;
        else edge_num[node] = 0;
      end
      gsp_pkg::CMD_ADD_EDGE: begin
        if (!is_live(node) || !is_live(nbr)) begin
          res.status = gsp_pkg::ST_ABSENT;
        end else if (edge_num[node] >= 8) begin
          res.status = gsp_pkg::ST_FULL;
        end else begin
          edge_target[node][edge_num[node]] = nbr;
          edge_weight[node][edge_num[node]] = ecost;
          edge_num[node]++;
        end
      end
      gsp_pkg::CMD_NAVIGATE: begin
        if (!is_live(start) || !is_live(goal)) res.status = gsp_pkg::ST_ABSENT;
        else res = find_route(start, goal);
        if (res.status == gsp_pkg::ST_OK) routes_found++;
      end
      default: ;
    endcase
    pending_results = {pending_results, res};
  endfunction

  function void check_result(logic [1:0] status, logic [5:0] node_out,
                             logic [23:0] path_cost);
    route_result_t exp;
    if (pending_results.size() == 0) begin
      $error("unexpected result: status %0d node_out %0d path_cost %0h",
             status, node_out, path_cost);
      errors++;
      return;
    end
    exp = pending_results.pop_front();
    checked++;
    if (status !== exp.status) begin
      $error("status: expected %0d, got %0d", exp.status, status);
      errors++;
    end
    if (node_out !== exp.node_out) begin
      $error("node_out: expected %0d, got %0d", exp.node_out, node_out);
      errors++;
    end
    if (path_cost !== exp.path_cost) begin
      $error("path_cost: expected %0h, got %0h", exp.path_cost, path_cost);
      errors++;
    end
  endfunction
endclass

// ===== bench/tb.sv =====
// Top of the graph next-hop core bench: drives commands with random gaps and
// result stalls, and checks every result. Depends on gsp_pkg, the channel
// interfaces, the core and tb_route_checker.
`timescale 1ns / 1ps

module tb;
  import gsp_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #2 clk_i = ~clk_i;

  gsp_in_if  cmd_ch();
  gsp_out_if res_ch();

  graph_shortest_path_next_hop_core DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (cmd_ch.sink),
    .out_o (res_ch.source)
  );

  route_checker routes = new();
  longint unsigned cycle_count = 0;
  bit              hold_results = 1'b0;
  bit              sending_done = 1'b0;
  int unsigned     sent_count = 0;

  initial begin
    cmd_ch.valid = 1'b0;
    cmd_ch.command = '0;
    cmd_ch.node_index = '0;
    cmd_ch.neighbor_index = '0;
    cmd_ch.edge_cost = '0;
    cmd_ch.destination_only = 1'b0;
    cmd_ch.start_node = '0;
    cmd_ch.goal_node = '0;
    res_ch.ready = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offers one command and waits for its transaction.
  task automatic send_command(int unsigned cmd, int unsigned node, int unsigned nbr,
                              int unsigned ecost, int unsigned dest, int unsigned start,
                              int unsigned goal);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.command <= 3'(cmd);
    cmd_ch.node_index <= 6'(node);
    cmd_ch.neighbor_index <= 6'(nbr);
    cmd_ch.edge_cost <= 16'(ecost);
    cmd_ch.destination_only <= 1'(dest);
    cmd_ch.start_node <= 6'(start);
    cmd_ch.goal_node <= 6'(goal);
    do @(posedge clk_i); while (!cmd_ch.ready);
    routes.note_command(3'(cmd), 6'(node), 6'(nbr), 16'(ecost), 1'(dest), 6'(start),
                        6'(goal));
    sent_count++;
  endtask

  task automatic send_random_command(int unsigned node_lim);
    logic [2:0] cmd;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) cmd = CMD_ADD_NODE;
    else if (r < 12) cmd = CMD_REMOVE;
    else if (r < 17) cmd = CMD_CLEAR;
    else if (r < 62) cmd = CMD_ADD_EDGE;
    else if (r < 97) cmd = CMD_NAVIGATE;
    else cmd = 3'($urandom_range(5, 7));
    send_command(cmd, 6'($urandom_range(0, node_lim)), 6'($urandom_range(0, node_lim)),
                 ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 1023)),
                 $urandom_range(0, 4) == 0, 6'($urandom_range(0, node_lim)),
                 6'($urandom_range(0, node_lim)));
  endtask

  // Stimulus.
  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed part: absent nodes, unknown command, small graph with ties,
    // a destination-only node, a self edge, start equal to goal, removal.
    send_command(CMD_NAVIGATE, 0, 0, 0, 0, 0, 0);
    send_command(CMD_REMOVE, 63, 0, 0, 0, 0, 0);
    send_command(3'd7, 6'h3F, 6'h3F, 16'hFFFF, 1, 6'h3F, 6'h3F);
    send_command(CMD_ADD_NODE, 0, 0, 0, 0, 0, 0);
    send_command(CMD_ADD_NODE, 0, 0, 0, 1, 0, 0);
    send_command(CMD_ADD_NODE, 0, 0, 0, 0, 0, 0);
    send_command(CMD_ADD_NODE, 0, 0, 0, 0, 0, 0);
    send_command(CMD_ADD_EDGE, 0, 1, 16'h0100, 0, 0, 0);
    send_command(CMD_ADD_EDGE, 1, 3, 16'h0100, 0, 0, 0);
    send_command(CMD_ADD_EDGE, 0, 2, 16'hFFFF, 0, 0, 0);
    send_command(CMD_ADD_EDGE, 2, 3, 16'hFFFF, 0, 0, 0);
    send_command(CMD_ADD_EDGE, 3, 3, 16'h0000, 0, 0, 0);
    send_command(CMD_ADD_EDGE, 3, 63, 16'h0001, 0, 0, 0);
    send_command(CMD_NAVIGATE, 0, 0, 0, 0, 3, 0);
    send_command(CMD_NAVIGATE, 0, 0, 0, 0, 2, 0);
    send_command(CMD_NAVIGATE, 0, 0, 0, 0, 3, 3);
    send_command(CMD_NAVIGATE, 0, 0, 0, 0, 0, 3);
    for (int k = 0; k < 6; k++) send_command(CMD_ADD_EDGE, 1, 0, 16'h00FF, 0, 0, 0);
    send_command(CMD_ADD_EDGE, 1, 0, 16'h0001, 0, 0, 0);
    send_command(CMD_NAVIGATE, 0, 0, 0, 0, 1, 0);
    send_command(CMD_CLEAR, 1, 0, 0, 0, 0, 0);
    send_command(CMD_REMOVE, 1, 0, 0, 0, 0, 0);
    send_command(CMD_NAVIGATE, 0, 0, 0, 0, 3, 0);
    // Random part on a growing table; the table runs full part way through.
    for (int n = 0; n < 1140; n++) begin
      if (n % 60 == 0) begin
        repeat (3) send_command(CMD_ADD_NODE, 0, 0, 0, $urandom_range(0, 5) == 0, 0, 0);
        for (int e = 0; e < 10; e++)
          send_command(CMD_ADD_EDGE, 6'($urandom_range(0, routes.free_index - 1)),
                       6'($urandom_range(0, routes.free_index - 1)),
                       16'($urandom_range(0, 4095)), 0, 0, 0);
        n += 13;
      end
      if (n == 400) hold_results = 1'b1;
      send_random_command(routes.free_index < 64 ? routes.free_index : 63);
      if (n == 415) hold_results = 1'b0;
    end
    cmd_ch.valid <= 1'b0;
    sending_done = 1'b1;
  end

  // Result side with random stalls and repeated long hold-offs while hold_results is set.
  initial begin
    int unsigned stall;
    int unsigned held;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (res_ch.valid && res_ch.ready)
        routes.check_result(res_ch.status, res_ch.node_out, res_ch.path_cost);
      if (hold_results) begin
        held = 0;
        res_ch.ready <= 1'b0;
        while (held < 3000) begin
          @(posedge clk_i);
          held++;
        end
      end
      if ($urandom_range(0, 2) == 0) begin
        stall = pick_gap();
        res_ch.ready <= (stall == 0);
        if (stall != 0) begin
          repeat (stall) @(posedge clk_i);
          res_ch.ready <= 1'b1;
          @(posedge clk_i);
          if (res_ch.valid && res_ch.ready)
            routes.check_result(res_ch.status, res_ch.node_out, res_ch.path_cost);
        end
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog and end of run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 40000000) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    wait (sending_done);
    while (routes.pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Checked %0d results from %0d commands; %0d navigations found a route.",
             routes.checked, sent_count, routes.routes_found);
    if (routes.errors == 0 && routes.pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
